// ===== design/vpvd_pkg.sv =====
// ----------------------------------------------------------------------------
// vpvd_pkg: shared types and constants of the palette voxel decoder
// Payload structs of both channels, the palette word, the queue operation and
// the configuration register indexes.
// ----------------------------------------------------------------------------
package vpvd_pkg;

  // Configuration register indexes (byte address is 4 times the index).
  localparam int          CFG_ADDR_W     = 5;
  localparam logic [2:0]  REG_VOL_WIDTH  = 3'd0;
  localparam logic [2:0]  REG_VOL_LENGTH = 3'd1;
  localparam logic [2:0]  REG_VOL_HEIGHT = 3'd2;
  localparam logic [2:0]  REG_BOUND_X    = 3'd3;
  localparam logic [2:0]  REG_BOUND_Y    = 3'd4;
  localparam logic [2:0]  REG_BOUND_Z    = 3'd5;
  localparam logic [2:0]  REG_AIR_CODE   = 3'd6;

  // Request types on the input channel.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // Varint assembly: the fifth byte always closes a value.
  localparam logic [2:0] VARINT_LAST_STEP = 3'd4;

  localparam int PALETTE_DEPTH_DEF = 4096;
  // Widest palette index the queue carries (depth of at most 65536).
  localparam int PAL_IDX_W         = 16;

  // Decoupling queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  typedef struct packed {
    logic        req_type;
    logic [11:0] slot;
    logic [7:0]  kind_in;
    logic [2:0]  dir_in;
    logic [15:0] aux_in;
    logic        ovr_in;
    logic [3:0]  level_in;
    logic        pow_in;
    logic        strong_in;
    logic [7:0]  data_byte;
    logic        end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [14:0] pos_z;
    logic [7:0]  kind_out;
    logic [2:0]  dir_out;
    logic [15:0] aux_out;
    logic        ovr_out;
    logic [3:0]  level_out;
    logic        pow_out;
    logic        strong_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [2:0]  dir;
    logic [15:0] aux;
    logic        ovr;
    logic [3:0]  level;
    logic        pw;
    logic        strong_pw;
  } pal_entry_t;

  typedef struct packed {
    logic       loaded;
    pal_entry_t entry;
  } pal_word_t;

  // One operation handed from the front to the back.
  typedef struct packed {
    logic                 is_load;
    logic [PAL_IDX_W-1:0] idx;
    pal_entry_t           entry;
    logic                 hit;      // lookup index valid and position inside bounds
    logic [14:0]          pos_x;
    logic [14:0]          pos_y;
    logic [14:0]          pos_z;
  } vpvd_op_t;

endpackage

// ===== design/vpvd_front.sv =====
// ----------------------------------------------------------------------------
// vpvd_front: input acceptance, varint assembly and voxel position tracking
// Turns each accepted transaction into at most one queue operation: a palette
// write or a palette lookup tagged with its position and bounds result.
// ----------------------------------------------------------------------------
module vpvd_front
  import vpvd_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  input  logic [14:0] vol_width,
  input  logic [14:0] vol_length,
  input  logic [14:0] vol_height,
  input  logic [15:0] bound_x,
  input  logic [15:0] bound_y,
  input  logic [15:0] bound_z,
  input  logic        clear_busy,
  input  logic        q_full,
  output logic        q_push,
  output vpvd_op_t    q_op
);

  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  byte_step_r, byte_step_nxt;
  logic [14:0] cur_x_r, cur_x_nxt;
  logic [14:0] cur_z_r, cur_z_nxt;
  logic [14:0] cur_y_r, cur_y_nxt;
  logic        volume_done_r, volume_done_nxt;

  logic        accept;
  logic [31:0] group;
  logic [31:0] value;
  logic        more;
  logic        slot_ok;
  logic        idx_ok;
  logic        in_bounds;
  logic        x_wrap, z_wrap, y_wrap;

  assign in_stall = clear_busy | q_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    unique case (byte_step_r)
      3'd0:    group = {25'd0, in_data.data_byte[6:0]};
      3'd1:    group = {18'd0, in_data.data_byte[6:0], 7'd0};
      3'd2:    group = {11'd0, in_data.data_byte[6:0], 14'd0};
      3'd3:    group = {4'd0, in_data.data_byte[6:0], 21'd0};
      default: group = {in_data.data_byte[3:0], 28'd0};
    endcase
  end

  assign value = accum_r | group;
  assign more  = in_data.data_byte[7] & (byte_step_r < VARINT_LAST_STEP)
               & ~in_data.end_of_data;

  assign slot_ok   = {20'd0, in_data.slot} < 32'(PALETTE_DEPTH);
  assign idx_ok    = ~value[31] & (value < 32'(PALETTE_DEPTH));
  assign in_bounds = ({1'b0, cur_x_r} < bound_x) & ({1'b0, cur_y_r} < bound_y)
                   & ({1'b0, cur_z_r} < bound_z);

  // A size of zero behaves as one, since the incremented counter always reaches it.
  assign x_wrap = ({1'b0, cur_x_r} + 16'd1) >= {1'b0, vol_width};
  assign z_wrap = ({1'b0, cur_z_r} + 16'd1) >= {1'b0, vol_length};
  assign y_wrap = ({1'b0, cur_y_r} + 16'd1) >= {1'b0, vol_height};

  always_comb begin
    accum_nxt       = accum_r;
    byte_step_nxt   = byte_step_r;
    cur_x_nxt       = cur_x_r;
    cur_z_nxt       = cur_z_r;
    cur_y_nxt       = cur_y_r;
    volume_done_nxt = volume_done_r;
    q_push          = 1'b0;

    q_op.is_load = (in_data.req_type == REQ_LOAD);
    q_op.idx     = (in_data.req_type == REQ_LOAD) ? PAL_IDX_W'(in_data.slot)
                                                  : value[PAL_IDX_W-1:0];
    q_op.entry.kind      = in_data.kind_in;
    q_op.entry.dir       = in_data.dir_in;
    q_op.entry.aux       = in_data.aux_in;
    q_op.entry.ovr       = in_data.ovr_in;
    q_op.entry.level     = in_data.level_in;
    q_op.entry.pw        = in_data.pow_in;
    q_op.entry.strong_pw = in_data.strong_in;
    q_op.hit   = idx_ok & in_bounds;
    q_op.pos_x = cur_x_r;
    q_op.pos_y = cur_y_r;
    q_op.pos_z = cur_z_r;

    if (accept) begin
      if (in_data.req_type == REQ_LOAD) begin
        q_push = slot_ok;
      end else if (!volume_done_r) begin
        if (more) begin
          accum_nxt     = value;
          byte_step_nxt = byte_step_r + 3'd1;
        end else begin
          accum_nxt     = '0;
          byte_step_nxt = '0;
          q_push        = 1'b1;
          // x runs innermost, then z, then y.
          cur_x_nxt = x_wrap ? '0 : cur_x_r + 15'd1;
          if (x_wrap) begin
            cur_z_nxt = z_wrap ? '0 : cur_z_r + 15'd1;
            if (z_wrap) begin
              cur_y_nxt = y_wrap ? '0 : cur_y_r + 15'd1;
              if (y_wrap) begin
                volume_done_nxt = 1'b1;
              end
            end
          end
          if (in_data.end_of_data) begin
            volume_done_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r       <= '0;
      byte_step_r   <= '0;
      cur_x_r       <= '0;
      cur_z_r       <= '0;
      cur_y_r       <= '0;
      volume_done_r <= 1'b0;
    end else begin
      accum_r       <= accum_nxt;
      byte_step_r   <= byte_step_nxt;
      cur_x_r       <= cur_x_nxt;
      cur_z_r       <= cur_z_nxt;
      cur_y_r       <= cur_y_nxt;
      volume_done_r <= volume_done_nxt;
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    volume_done_r |=> volume_done_r)
    else $error("volume done flag cleared without reset");

endmodule

// ===== design/vpvd_queue.sv =====
// ----------------------------------------------------------------------------
// vpvd_queue: short operation queue between front and back
// A small register FIFO so that the front keeps accepting while the back
// waits on the result channel.
// ----------------------------------------------------------------------------
module vpvd_queue
  import vpvd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  vpvd_op_t push_op,
  output logic     full,
  output logic     head_valid,
  output vpvd_op_t head_op,
  input  logic     pop
);

  vpvd_op_t           slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/vpvd_back.sv =====
// ----------------------------------------------------------------------------
// vpvd_back: palette memory, lookup stage and result register
// Executes queued palette writes and lookups in order, clears the palette
// after reset and presents results on the output channel.
// ----------------------------------------------------------------------------
module vpvd_back
  import vpvd_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] air_code,
  input  logic       q_valid,
  input  vpvd_op_t   q_op,
  output logic       q_pop,
  output logic       clear_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  pal_word_t   mem [PALETTE_DEPTH];

  logic          clear_busy_r, clear_busy_nxt;
  logic [AW-1:0] clear_cnt_r, clear_cnt_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic [14:0] s1_x_r, s1_y_r, s1_z_r;
  pal_word_t   rd_word_r;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  pal_word_t     wr_word;
  logic          rd_en;
  logic          emit;
  logic          s1_adv;
  logic          out_load;

  assign clear_busy = clear_busy_r;

  assign emit   = s1_valid_r & rd_word_r.loaded & (rd_word_r.entry.kind != air_code);
  assign s1_adv = s1_valid_r & (~emit | ~out_valid_r | ~out_stall);
  assign q_pop  = q_valid & ~clear_busy_r & (~s1_valid_r | s1_adv);
  assign rd_en  = q_pop & ~q_op.is_load & q_op.hit;
  assign out_load = s1_adv & emit;

  // The clearing pass owns the write port until it has swept every entry.
  always_comb begin
    wr_en   = clear_busy_r | (q_pop & q_op.is_load);
    wr_addr = clear_busy_r ? clear_cnt_r : q_op.idx[AW-1:0];
    wr_word = clear_busy_r ? pal_word_t'('0) : {1'b1, q_op.entry};
  end

  always_comb begin
    clear_cnt_nxt  = clear_cnt_r;
    clear_busy_nxt = clear_busy_r;
    if (clear_busy_r) begin
      clear_cnt_nxt = clear_cnt_r + AW'(1);
      if (clear_cnt_r == AW'(PALETTE_DEPTH - 1)) begin
        clear_busy_nxt = 1'b0;
      end
    end
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem[q_op.idx[AW-1:0]];
      s1_x_r    <= q_op.pos_x;
      s1_y_r    <= q_op.pos_y;
      s1_z_r    <= q_op.pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pos_x      <= s1_x_r;
      out_data_r.pos_y      <= s1_y_r;
      out_data_r.pos_z      <= s1_z_r;
      out_data_r.kind_out   <= rd_word_r.entry.kind;
      out_data_r.dir_out    <= rd_word_r.entry.dir;
      out_data_r.aux_out    <= rd_word_r.entry.aux;
      out_data_r.ovr_out    <= rd_word_r.entry.ovr;
      out_data_r.level_out  <= rd_word_r.entry.level;
      out_data_r.pow_out    <= rd_word_r.entry.pw;
      out_data_r.strong_out <= rd_word_r.entry.strong_pw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clear_cnt_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clear_busy_r <= clear_busy_nxt;
      clear_cnt_r  <= clear_cnt_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy_r |-> !q_pop)
    else $error("queue popped during palette clearing");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clear_busy_r |=> !clear_busy_r)
    else $error("palette clearing restarted without reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("held result overwritten");

endmodule

// ===== design/varint_palette_voxel_decoder.sv =====
// ----------------------------------------------------------------------------
// varint_palette_voxel_decoder: palette-indexed voxel decoder
// Loads a palette, assembles base-128 varints from block data and emits one
// placed voxel per in-bounds index naming a loaded, non-air palette entry.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries palette loads and
//   block-data bytes; a transaction is taken at a clock edge with in_valid
//   high and in_stall low. The result channel (out_valid, out_stall,
//   out_data) carries placed voxels, one per completed varint at most.
//   Configuration registers are written through the APB port at byte address
//   4 times the register index, by the user only while the decoder is idle;
//   the block does not enforce this. Throughput is one input transaction per
//   cycle while in_stall is low. A result passes from the transaction that
//   completes its varint through the operation queue, the registered palette
//   read and the result register. After reset the PALETTE_DEPTH (default
//   4096) palette entries are cleared one per cycle, in_stall high meanwhile.
//   When out_stall is held, the result register keeps its transaction, the
//   lookup stage and then the four-entry queue fill, and in_stall rises once
//   the queue is full. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module varint_palette_voxel_decoder
  import vpvd_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [14:0] vol_width_r, vol_length_r, vol_height_r;
  logic [15:0] bound_x_r, bound_y_r, bound_z_r;
  logic [7:0]  air_code_r;

  logic       cfg_wr;
  logic [2:0] reg_idx;

  logic     clear_busy;
  logic     q_full;
  logic     q_push;
  vpvd_op_t q_push_op;
  logic     q_valid;
  vpvd_op_t q_head_op;
  logic     q_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_width_r  <= 15'd1;
      vol_length_r <= 15'd1;
      vol_height_r <= 15'd1;
      bound_x_r    <= '0;
      bound_y_r    <= '0;
      bound_z_r    <= '0;
      air_code_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_VOL_WIDTH:  vol_width_r  <= pwdata[14:0];
        REG_VOL_LENGTH: vol_length_r <= pwdata[14:0];
        REG_VOL_HEIGHT: vol_height_r <= pwdata[14:0];
        REG_BOUND_X:    bound_x_r    <= pwdata[15:0];
        REG_BOUND_Y:    bound_y_r    <= pwdata[15:0];
        REG_BOUND_Z:    bound_z_r    <= pwdata[15:0];
        REG_AIR_CODE:   air_code_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VOL_WIDTH:  prdata = {17'd0, vol_width_r};
      REG_VOL_LENGTH: prdata = {17'd0, vol_length_r};
      REG_VOL_HEIGHT: prdata = {17'd0, vol_height_r};
      REG_BOUND_X:    prdata = {16'd0, bound_x_r};
      REG_BOUND_Y:    prdata = {16'd0, bound_y_r};
      REG_BOUND_Z:    prdata = {16'd0, bound_z_r};
      REG_AIR_CODE:   prdata = {24'd0, air_code_r};
      default:        prdata = '0;
    endcase
  end

  vpvd_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .vol_width  (vol_width_r),
    .vol_length (vol_length_r),
    .vol_height (vol_height_r),
    .bound_x    (bound_x_r),
    .bound_y    (bound_y_r),
    .bound_z    (bound_z_r),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (q_push_op)
  );

  vpvd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .head_valid (q_valid),
    .head_op    (q_head_op),
    .pop        (q_pop)
  );

  vpvd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .air_code   (air_code_r),
    .q_valid    (q_valid),
    .q_op       (q_head_op),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
